// File: hdl/brg_pkg.sv
// ----------------------------------------------------------------------------
// brg_pkg
// shared types, codes and default sizes of the resource grant engine
// ----------------------------------------------------------------------------
package brg_pkg;

    localparam int DEF_CUSTOMERS  = 8;
    localparam int DEF_RESOURCES  = 4;
    localparam int DEF_COUNT_BITS = 16;

    // widest count the engine is built for
    localparam int MAX_COUNT_BITS = 32;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_TOTAL   = 2'd1,
        ACT_START   = 2'd2,
        ACT_ATTEMPT = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        STAT_LOADED       = 4'd0,
        STAT_HELD_OVER    = 4'd1,
        STAT_TOTAL_SET    = 4'd2,
        STAT_STARTED      = 4'd3,
        STAT_STARTED_OVER = 4'd4,
        STAT_GRANTED      = 4'd5,
        STAT_REFUSED      = 4'd6,
        STAT_DEADLOCK     = 4'd7,
        STAT_COMPLETED    = 4'd8
    } t_status;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  customer;
        logic [1:0]  resource;
        logic [15:0] max_count;
        logic [15:0] alloc_count;
        logic [15:0] total_count;
    } t_in_item;

    typedef struct packed {
        logic [3:0] status;
        logic [2:0] customer_echo;
        logic [2:0] sequence_position;
        logic       all_done;
    } t_out_item;

endpackage

// File: hdl/brg_ram.sv
// ----------------------------------------------------------------------------
// brg_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module brg_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 32,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bankers_resource_grant_engine_core.sv
// ----------------------------------------------------------------------------
// bankers_resource_grant_engine_core
// banker's style grant engine: need and held counts live in two rams
// ----------------------------------------------------------------------------
// load and set total give their result in the cycle after the item is taken
// start: a pass over the held ram, one held entry read from ram per cycle
// attempt: if refused, a check pass over the need/held rams; if granted, that
//   check pass, then a write-back pass clearing held units
// one item at a time: busy stays high until its result strobe; results cannot
//   be stalled. synchronous active-low reset clears totals, available counts,
//   completion and refusal flags; ram contents are undefined until loaded
module bankers_resource_grant_engine_core #(
    parameter int CUSTOMERS  = brg_pkg::DEF_CUSTOMERS,
    parameter int RESOURCES  = brg_pkg::DEF_RESOURCES,
    parameter int COUNT_BITS = brg_pkg::DEF_COUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  brg_pkg::t_in_item   i_item,
    output logic                o_result_strobe,
    output brg_pkg::t_out_item  o_result
);

    import brg_pkg::*;

    // index widths; entry address is {customer, resource}
    localparam int CUST_BITS = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
    localparam int RES_BITS  = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int ADDR_BITS = CUST_BITS + RES_BITS;
    localparam int DEPTH     = 2 ** ADDR_BITS;
    localparam int GC_BITS   = $clog2(CUSTOMERS + 1);
    // a sum of CUSTOMERS counts cannot overflow this
    localparam int SUM_BITS  = COUNT_BITS + GC_BITS;

    localparam logic [CUST_BITS-1:0] CUST_LAST = CUST_BITS'(CUSTOMERS - 1);
    localparam logic [RES_BITS-1:0]  RES_LAST  = RES_BITS'(RESOURCES - 1);
    localparam logic [GC_BITS-1:0]   GC_FULL   = GC_BITS'(CUSTOMERS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_CHECK,
        S_GRANT
    } t_state;

    // ------------------------------------------------------------------------
    // registers and their next values
    // ------------------------------------------------------------------------
    t_state                 r_state, n_state;
    logic                   r_strobe, n_strobe;
    t_out_item              r_out, n_out;

    logic [CUST_BITS-1:0]   r_cust, n_cust;        // customer under attempt
    logic [2:0]             r_echo, n_echo;        // its index as given
    logic                   r_fits, n_fits;        // need fits so far
    logic                   r_over, n_over;        // some resource overcommitted
    logic [SUM_BITS-1:0]    r_acc, n_acc;          // running held sum

    // read issue side
    logic                   r_iss, n_iss;
    logic [RES_BITS-1:0]    r_iss_res, n_iss_res;
    logic [CUST_BITS-1:0]   r_iss_cust, n_iss_cust;

    // tags that travel alongside the ram read
    logic                   r_rd_vld, n_rd_vld;
    logic [RES_BITS-1:0]    r_rd_res, n_rd_res;
    logic                   r_rd_first, n_rd_first;
    logic                   r_rd_lastc, n_rd_lastc;
    logic                   r_rd_final, n_rd_final;

    logic [RES_BITS-1:0]    r_g_res, n_g_res;      // write-back pass index

    logic [CUSTOMERS-1:0]   r_done, n_done;
    logic [CUSTOMERS-1:0]   r_refused, n_refused;
    logic [GC_BITS-1:0]     r_grant_cnt, n_grant_cnt;

    logic [COUNT_BITS-1:0]  r_total [RESOURCES];
    logic [COUNT_BITS-1:0]  n_total [RESOURCES];
    logic [COUNT_BITS-1:0]  r_avail [RESOURCES];
    logic [COUNT_BITS-1:0]  n_avail [RESOURCES];
    logic [COUNT_BITS-1:0]  r_held_buf [RESOURCES];
    logic [COUNT_BITS-1:0]  n_held_buf [RESOURCES];

    // ------------------------------------------------------------------------
    // ram ports
    // ------------------------------------------------------------------------
    logic                   need_we;
    logic                   held_we;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [COUNT_BITS-1:0]  need_wdata;
    logic [COUNT_BITS-1:0]  held_wdata;
    logic [COUNT_BITS-1:0]  need_rdata;
    logic [COUNT_BITS-1:0]  held_rdata;

    brg_ram #(
        .WIDTH     (COUNT_BITS),
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS)
    ) u_need_ram (
        .i_clk   (i_clk),
        .i_we    (need_we),
        .i_waddr (wr_addr),
        .i_wdata (need_wdata),
        .i_raddr (rd_addr),
        .o_rdata (need_rdata)
    );

    brg_ram #(
        .WIDTH     (COUNT_BITS),
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS)
    ) u_held_ram (
        .i_clk   (i_clk),
        .i_we    (held_we),
        .i_waddr (wr_addr),
        .i_wdata (held_wdata),
        .i_raddr (rd_addr),
        .o_rdata (held_rdata)
    );

    // ------------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------------
    logic                   accept;
    logic [31:0]            in_cust_wide;
    logic [31:0]            in_res_wide;
    logic [CUST_BITS-1:0]   in_cust_idx;
    logic [RES_BITS-1:0]    in_res_idx;
    logic                   in_cust_ok;
    logic                   in_res_ok;
    logic [MAX_COUNT_BITS-1:0] in_max_wide;
    logic [MAX_COUNT_BITS-1:0] in_alloc_wide;
    logic [MAX_COUNT_BITS-1:0] in_total_wide;
    logic [COUNT_BITS-1:0]  in_max;
    logic [COUNT_BITS-1:0]  in_alloc;
    logic [COUNT_BITS-1:0]  in_total;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign in_cust_wide  = 32'(i_item.customer);
    assign in_res_wide   = 32'(i_item.resource);
    assign in_cust_idx   = in_cust_wide[CUST_BITS-1:0];
    assign in_res_idx    = in_res_wide[RES_BITS-1:0];
    assign in_cust_ok    = (in_cust_wide < 32'(CUSTOMERS));
    assign in_res_ok     = (in_res_wide < 32'(RESOURCES));

    // counts are cut to the configured width before any use
    assign in_max_wide   = MAX_COUNT_BITS'(i_item.max_count);
    assign in_alloc_wide = MAX_COUNT_BITS'(i_item.alloc_count);
    assign in_total_wide = MAX_COUNT_BITS'(i_item.total_count);
    assign in_max        = in_max_wide[COUNT_BITS-1:0];
    assign in_alloc      = in_alloc_wide[COUNT_BITS-1:0];
    assign in_total      = in_total_wide[COUNT_BITS-1:0];

    // ------------------------------------------------------------------------
    // datapath pieces
    // ------------------------------------------------------------------------
    // start pass: held sum per resource against its total
    logic [SUM_BITS-1:0]    sum_next;
    logic [SUM_BITS-1:0]    total_ext;
    logic                   sum_over;
    logic [COUNT_BITS-1:0]  sum_avail;

    assign sum_next  = (r_rd_first ? '0 : r_acc) + SUM_BITS'(held_rdata);
    assign total_ext = SUM_BITS'(r_total[r_rd_res]);
    assign sum_over  = (sum_next > total_ext);
    assign sum_avail = COUNT_BITS'(total_ext - sum_next);

    // write-back pass: returned units saturate at full scale
    logic [COUNT_BITS:0]    ret_sum;
    logic [COUNT_BITS-1:0]  ret_avail;

    assign ret_sum   = {1'b0, r_avail[r_g_res]} + {1'b0, r_held_buf[r_g_res]};
    assign ret_avail = ret_sum[COUNT_BITS] ? '1 : ret_sum[COUNT_BITS-1:0];

    logic [31:0]            pos_wide;

    assign pos_wide = 32'(r_grant_cnt);

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_strobe    = 1'b0;
        n_out       = r_out;
        n_cust      = r_cust;
        n_echo      = r_echo;
        n_fits      = r_fits;
        n_over      = r_over;
        n_acc       = r_acc;
        n_iss       = r_iss;
        n_iss_res   = r_iss_res;
        n_iss_cust  = r_iss_cust;
        n_g_res     = r_g_res;
        n_done      = r_done;
        n_refused   = r_refused;
        n_grant_cnt = r_grant_cnt;
        n_total     = r_total;
        n_avail     = r_avail;
        n_held_buf  = r_held_buf;

        // tags follow the read issued this cycle
        n_rd_vld    = r_iss;
        n_rd_res    = r_iss_res;
        n_rd_first  = (r_iss_cust == '0);
        n_rd_lastc  = (r_iss_cust == CUST_LAST);
        n_rd_final  = (r_iss_res == RES_LAST)
                      && ((r_state == S_CHECK) || (r_iss_cust == CUST_LAST));

        need_we     = 1'b0;
        held_we     = 1'b0;
        wr_addr     = {in_cust_idx, in_res_idx};
        need_wdata  = in_max - in_alloc;
        held_wdata  = in_alloc;
        rd_addr     = {((r_state == S_SUM) ? r_iss_cust : r_cust), r_iss_res};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out = '0;
                    case (t_action'(i_item.action))
                        ACT_LOAD: begin
                            n_out.customer_echo = i_item.customer;
                            if (!in_cust_ok || !in_res_ok || (in_alloc > in_max)) begin
                                n_out.status = STAT_HELD_OVER;
                            end else begin
                                need_we      = 1'b1;
                                held_we      = 1'b1;
                                n_out.status = STAT_LOADED;
                            end
                            n_strobe = 1'b1;
                        end
                        ACT_TOTAL: begin
                            if (in_res_ok) begin
                                n_total[in_res_idx] = in_total;
                            end
                            n_out.status = STAT_TOTAL_SET;
                            n_strobe     = 1'b1;
                        end
                        ACT_START: begin
                            // fresh run: nobody done, nobody refused
                            n_done      = '0;
                            n_refused   = '0;
                            n_grant_cnt = '0;
                            n_over      = 1'b0;
                            n_iss       = 1'b1;
                            n_iss_res   = '0;
                            n_iss_cust  = '0;
                            n_state     = S_SUM;
                        end
                        ACT_ATTEMPT: begin
                            n_out.customer_echo = i_item.customer;
                            if (!in_cust_ok) begin
                                n_out.status = STAT_REFUSED;
                                n_strobe     = 1'b1;
                            end else if (r_done[in_cust_idx]) begin
                                n_out.status = STAT_COMPLETED;
                                n_strobe     = 1'b1;
                            end else begin
                                n_cust    = in_cust_idx;
                                n_echo    = i_item.customer;
                                n_fits    = 1'b1;
                                n_iss     = 1'b1;
                                n_iss_res = '0;
                                n_state   = S_CHECK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SUM: begin
                // walk customers fastest, then resources
                if (r_iss) begin
                    if (r_iss_cust == CUST_LAST) begin
                        n_iss_cust = '0;
                        if (r_iss_res == RES_LAST) begin
                            n_iss = 1'b0;
                        end else begin
                            n_iss_res = r_iss_res + 1'b1;
                        end
                    end else begin
                        n_iss_cust = r_iss_cust + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    n_acc = sum_next;
                    if (r_rd_lastc) begin
                        n_avail[r_rd_res] = sum_over ? '0 : sum_avail;
                        n_over            = r_over || sum_over;
                    end
                    if (r_rd_final) begin
                        n_out.status        = n_over ? STAT_STARTED_OVER : STAT_STARTED;
                        n_out.customer_echo = '0;
                        n_out.sequence_position = '0;
                        n_strobe            = 1'b1;
                        n_state             = S_IDLE;
                    end
                end
            end

            S_CHECK: begin
                if (r_iss) begin
                    if (r_iss_res == RES_LAST) begin
                        n_iss = 1'b0;
                    end else begin
                        n_iss_res = r_iss_res + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    // keep held units for the write-back pass
                    n_held_buf[r_rd_res] = held_rdata;
                    n_fits = r_fits && !(need_rdata > r_avail[r_rd_res]);
                    if (r_rd_final) begin
                        if (n_fits) begin
                            n_g_res = '0;
                            n_state = S_GRANT;
                        end else begin
                            n_refused[r_cust] = 1'b1;
                            // deadlock once every unfinished customer is refused
                            n_out.status = (&(n_refused | r_done)) ? STAT_DEADLOCK
                                                                    : STAT_REFUSED;
                            n_out.customer_echo     = r_echo;
                            n_out.sequence_position = '0;
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                end
            end

            S_GRANT: begin
                // return held units and clear the entry, one resource a cycle
                n_avail[r_g_res] = ret_avail;
                held_we          = 1'b1;
                wr_addr          = {r_cust, r_g_res};
                held_wdata       = '0;
                if (r_g_res == RES_LAST) begin
                    n_done[r_cust] = 1'b1;
                    // grant re-arms everyone still running
                    n_refused      = '0;
                    if (r_grant_cnt != GC_FULL) begin
                        n_grant_cnt = r_grant_cnt + 1'b1;
                    end
                    n_out.status            = STAT_GRANTED;
                    n_out.customer_echo     = r_echo;
                    n_out.sequence_position = pos_wide[2:0];
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_g_res = r_g_res + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out.all_done = (n_grant_cnt == GC_FULL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_strobe    <= 1'b0;
            r_iss       <= 1'b0;
            r_iss_res   <= '0;
            r_iss_cust  <= '0;
            r_rd_vld    <= 1'b0;
            r_g_res     <= '0;
            r_done      <= '0;
            r_refused   <= '0;
            r_grant_cnt <= '0;
            r_total     <= '{default: '0};
            r_avail     <= '{default: '0};
        end else begin
            r_state     <= n_state;
            r_strobe    <= n_strobe;
            r_iss       <= n_iss;
            r_iss_res   <= n_iss_res;
            r_iss_cust  <= n_iss_cust;
            r_rd_vld    <= n_rd_vld;
            r_g_res     <= n_g_res;
            r_done      <= n_done;
            r_refused   <= n_refused;
            r_grant_cnt <= n_grant_cnt;
            r_total     <= n_total;
            r_avail     <= n_avail;
        end
        // payload, no reset needed
        r_out      <= n_out;
        r_cust     <= n_cust;
        r_echo     <= n_echo;
        r_fits     <= n_fits;
        r_over     <= n_over;
        r_acc      <= n_acc;
        r_rd_res   <= n_rd_res;
        r_rd_first <= n_rd_first;
        r_rd_lastc <= n_rd_lastc;
        r_rd_final <= n_rd_final;
        r_held_buf <= n_held_buf;
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_out;

endmodule
